>>> hdl/multicolor_bitmap_pixel_encoder_macros.svh
// Assertion macros used by the encoder top module.
`ifndef MULTICOLOR_BITMAP_PIXEL_ENCODER_MACROS_SVH
`define MULTICOLOR_BITMAP_PIXEL_ENCODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBPE_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MBPE_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/mbpe_pkg.sv
`default_nettype none

package mbpe_pkg;

	localparam int MAX_WIDTH  = 160;
	localparam int MAX_HEIGHT = 200;

	localparam int CH_W       = 8;
	localparam int NUM_COLORS = 4;
	localparam int IDX_W      = 2;
	localparam int RGB_W      = 3 * CH_W;
	localparam int CODES_W    = 16;
	localparam int WIDTH_W    = 6;
	localparam int HEIGHT_W   = 8;
	localparam int POS_W      = 8;

	// Squared distance of three channels and its integer square root.
	localparam int SQ_W      = 2 * CH_W + 2;
	localparam int ROOT_W    = SQ_W / 2;
	localparam int REM_W     = ROOT_W + 1;
	localparam int NUM_CELLS = ROOT_W;

	localparam int BADDR_W = 13;
	localparam int CADDR_W = 14;
	localparam int CVAL_W  = 4;
	localparam int ROWW_W  = 11;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [WIDTH_W-1:0]  W_LIMIT = WIDTH_W'(MAX_WIDTH / 4);
	localparam logic [HEIGHT_W-1:0] H_LIMIT = HEIGHT_W'(MAX_HEIGHT);
	localparam logic [WIDTH_W-1:0]  W_RESET = WIDTH_W'(40);
	localparam logic [HEIGHT_W-1:0] H_RESET = HEIGHT_W'(200);

	// Color map actions; the action equals the chosen palette index.
	localparam logic [IDX_W-1:0] ACT_NONE  = 2'd0;
	localparam logic [IDX_W-1:0] ACT_HIGH  = 2'd1;
	localparam logic [IDX_W-1:0] ACT_LOW   = 2'd2;
	localparam logic [IDX_W-1:0] ACT_BYTE  = 2'd3;

	typedef enum logic [2:0] {
		REG_PAL0   = 3'd0,
		REG_PAL1   = 3'd1,
		REG_PAL2   = 3'd2,
		REG_PAL3   = 3'd3,
		REG_CODES  = 3'd4,
		REG_WIDTH  = 3'd5,
		REG_HEIGHT = 3'd6
	} reg_idx_t;

	// Configuration as the datapath sees it, width and height already limited.
	typedef struct packed {
		logic [NUM_COLORS-1:0][RGB_W-1:0] palette;
		logic [CODES_W-1:0]               codes;
		logic [WIDTH_W-1:0]               width;
		logic [HEIGHT_W-1:0]              height;
	} cfg_t;

	typedef struct packed {
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
	} pix_t;

	// Word handed from one square-root cell to the next, one lane per palette entry.
	typedef struct packed {
		logic [NUM_COLORS-1:0][SQ_W-1:0]   rad;
		logic [NUM_COLORS-1:0][REM_W-1:0]  rem;
		logic [NUM_COLORS-1:0][ROOT_W-1:0] root;
		logic [POS_W-1:0]                  x;
		logic [POS_W-1:0]                  y;
	} sqw_t;

	typedef struct packed {
		logic [IDX_W-1:0]   index;
		logic [BADDR_W-1:0] baddr;
		logic [CH_W-1:0]    bits;
		logic [CADDR_W-1:0] caddr;
		logic [CVAL_W-1:0]  cval;
	} res_t;

endpackage

`default_nettype wire

>>> hdl/multicolor_bitmap_pixel_encoder.sv
// Channel  Dir  Handshake                    Word contents
// pixel    in   pixel_valid / pixel_stall    red, green, blue, pixel_x, pixel_y
// result   out  result_valid / result_stall  index, bitmap address and bits, color map write
// config   in   APB, pready tied high        palette, color codes, width, height
//
// One pixel word is taken every clock while pixel_stall is low; it passes the input and
// distance stages, nine square-root cells (one per root bit), then selection and output.
// Reset (arst_n low) empties the pipeline and loads the register reset values.
// A stalled result holds in the output register; the next word parks in a skid
// register and pixel_stall rises, freezing the whole pipeline until the skid drains.
`default_nettype none
`include "multicolor_bitmap_pixel_encoder_macros.svh"

module multicolor_bitmap_pixel_encoder import mbpe_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Pixel channel.
	input  wire logic               pixel_valid,
	output logic                    pixel_stall,
	input  wire logic [CH_W-1:0]    red,
	input  wire logic [CH_W-1:0]    green,
	input  wire logic [CH_W-1:0]    blue,
	input  wire logic [POS_W-1:0]   pixel_x,
	input  wire logic [POS_W-1:0]   pixel_y,
	// Result channel.
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic [IDX_W-1:0]        chosen_index,
	output logic [BADDR_W-1:0]      bitmap_address,
	output logic [CH_W-1:0]         bitmap_bits,
	output logic [IDX_W-1:0]        color_action,
	output logic [CADDR_W-1:0]      color_address,
	output logic [CVAL_W-1:0]       color_value,
	// Configuration port.
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	cfg_t cfg;

	// The pipeline moves as one whenever the skid register is free.
	logic en;
	logic accept;

	logic valid_s1;
	pix_t pix_s1;

	logic valid_chain [NUM_CELLS+1];
	sqw_t word_chain  [NUM_CELLS+1];

	logic                 valid_s12;
	logic [IDX_W-1:0]     index_s12;
	logic [POS_W-1:0]     x_s12;
	logic [POS_W-1:0]     y_s12;
	logic [ROWW_W-1:0]    roww_s12;
	logic [CADDR_W-1:0]   wh_s12;
	logic [ROWW_W-1:0]    wh8_s12;
	logic [CVAL_W-1:0]    cval_s12;

	logic [IDX_W-1:0]     pick_index;
	logic [CVAL_W-1:0]    pick_cval;

	res_t arr;
	logic arr_valid;
	logic load_out;

	logic out_valid_q;
	res_t out_q;
	logic skid_valid_q;
	res_t skid_q;

	assign pready      = 1'b1;
	assign en          = !skid_valid_q;
	assign pixel_stall = skid_valid_q;
	assign accept      = pixel_valid && !pixel_stall;

	mbpe_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1.red   <= red;
			pix_s1.green <= green;
			pix_s1.blue  <= blue;
			pix_s1.x     <= pixel_x;
			pix_s1.y     <= pixel_y;
		end
	end

	// Squared distance to all four palette entries.
	mbpe_dist_stage u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s1),
		.pix       (pix_s1),
		.palette   (cfg.palette),
		.out_valid (valid_chain[0]),
		.out_word  (word_chain[0])
	);

	// Square-root chain: each cell resolves one bit of every lane's root,
	// most significant first.
	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		mbpe_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (valid_chain[k]),
			.in_word   (word_chain[k]),
			.out_valid (valid_chain[k+1]),
			.out_word  (word_chain[k+1])
		);
	end

	// Nearest entry: strict less-than keeps the lowest index on a tie.
	always_comb begin
		logic [ROOT_W-1:0]  best;
		logic [CODES_W-1:0] sh;
		best       = word_chain[NUM_CELLS].root[0];
		pick_index = ACT_NONE;
		for (int i = 1; i < NUM_COLORS; i++) begin
			if (word_chain[NUM_CELLS].root[i] < best) begin
				best       = word_chain[NUM_CELLS].root[i];
				pick_index = IDX_W'(i);
			end
		end
		sh        = cfg.codes >> {pick_index, 2'b00};
		pick_cval = (pick_index == ACT_NONE) ? '0 : sh[CVAL_W-1:0];
	end

	// Selection stage also forms the small products the addresses need.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s12 <= 1'b0;
		end else if (en) begin
			valid_s12 <= valid_chain[NUM_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_chain[NUM_CELLS]) begin
			index_s12 <= pick_index;
			x_s12     <= word_chain[NUM_CELLS].x;
			y_s12     <= word_chain[NUM_CELLS].y;
			roww_s12  <= ROWW_W'(word_chain[NUM_CELLS].y[POS_W-1:3]) * ROWW_W'(cfg.width);
			wh_s12    <= CADDR_W'(cfg.width) * CADDR_W'(cfg.height);
			wh8_s12   <= ROWW_W'(cfg.width) * ROWW_W'(cfg.height[HEIGHT_W-1:3]);
			cval_s12  <= pick_cval;
		end
	end

	// Address assembly. Positions outside the image simply wrap.
	always_comb begin
		logic [CADDR_W-1:0] bsum;
		logic [ROWW_W:0]    cell_num;
		logic [CADDR_W-1:0] base;
		bsum = CADDR_W'(2) + {roww_s12, 3'b000} + CADDR_W'({x_s12[POS_W-1:2], 3'b000})
			+ CADDR_W'(y_s12[2:0]);
		cell_num = (ROWW_W+1)'(roww_s12) + (ROWW_W+1)'(x_s12[POS_W-1:2]);
		base = CADDR_W'(2) + wh_s12 + CADDR_W'(cell_num);
		arr.index = index_s12;
		arr.baddr = bsum[BADDR_W-1:0];
		unique case (x_s12[1:0])
			2'd0: arr.bits = {index_s12, 6'b000000};
			2'd1: arr.bits = {2'b00, index_s12, 4'b0000};
			2'd2: arr.bits = {4'b0000, index_s12, 2'b00};
			2'd3: arr.bits = {6'b000000, index_s12};
			default: arr.bits = '0;
		endcase
		unique case (index_s12)
			ACT_NONE: arr.caddr = '0;
			ACT_HIGH,
			ACT_LOW:  arr.caddr = base;
			ACT_BYTE: arr.caddr = base + CADDR_W'(wh8_s12);
			default:  arr.caddr = '0;
		endcase
		arr.cval = cval_s12;
	end

	assign arr_valid = valid_s12 && en;
	assign load_out  = !out_valid_q || !result_stall;

	// Output register with a one-word skid behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q  <= skid_valid_q || arr_valid;
			skid_valid_q <= 1'b0;
		end else if (arr_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= skid_valid_q ? skid_q : arr;
		end else if (arr_valid) begin
			skid_q <= arr;
		end
	end

	assign result_valid   = out_valid_q;
	assign chosen_index   = out_q.index;
	assign bitmap_address = out_q.baddr;
	assign bitmap_bits    = out_q.bits;
	assign color_action   = out_q.index;
	assign color_address  = out_q.caddr;
	assign color_value    = out_q.cval;

	`MBPE_ASSERT_SAME(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q, "skid word without output word")
	`MBPE_ASSERT_NEXT(a_skid_holds, clk, arst_n, skid_valid_q && result_stall, skid_valid_q, "skid word lost under stall")
	`MBPE_ASSERT_NEXT(a_accept_enters, clk, arst_n, accept, valid_s1, "accepted pixel missing from input stage")
	`MBPE_ASSERT_SAME(a_no_action_zero, clk, arst_n, result_valid && chosen_index == ACT_NONE, color_address == '0 && color_value == '0, "color fields set for entry zero")

endmodule

`default_nettype wire

>>> hdl/mbpe_cfg_regs.sv
`default_nettype none

module mbpe_cfg_regs import mbpe_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output cfg_t                    cfg
);

	logic [NUM_COLORS-1:0][RGB_W-1:0] pal_q;
	logic [CODES_W-1:0]               codes_q;
	logic [WIDTH_W-1:0]               width_q;
	logic [HEIGHT_W-1:0]              height_q;
	reg_idx_t                         idx;
	logic                             wr;

	assign idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_q    <= '0;
			codes_q  <= '0;
			width_q  <= W_RESET;
			height_q <= H_RESET;
		end else if (wr) begin
			unique case (idx)
				REG_PAL0:   pal_q[0] <= pwdata[RGB_W-1:0];
				REG_PAL1:   pal_q[1] <= pwdata[RGB_W-1:0];
				REG_PAL2:   pal_q[2] <= pwdata[RGB_W-1:0];
				REG_PAL3:   pal_q[3] <= pwdata[RGB_W-1:0];
				REG_CODES:  codes_q  <= pwdata[CODES_W-1:0];
				REG_WIDTH:  width_q  <= pwdata[WIDTH_W-1:0];
				REG_HEIGHT: height_q <= pwdata[HEIGHT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PAL0:   prdata = PDATA_W'(pal_q[0]);
			REG_PAL1:   prdata = PDATA_W'(pal_q[1]);
			REG_PAL2:   prdata = PDATA_W'(pal_q[2]);
			REG_PAL3:   prdata = PDATA_W'(pal_q[3]);
			REG_CODES:  prdata = PDATA_W'(codes_q);
			REG_WIDTH:  prdata = PDATA_W'(width_q);
			REG_HEIGHT: prdata = PDATA_W'(height_q);
			default:    prdata = '0;
		endcase
	end

	// Oversized width or height is used at the limit; zero passes through.
	always_comb begin
		cfg.palette = pal_q;
		cfg.codes   = codes_q;
		cfg.width   = (width_q > W_LIMIT) ? W_LIMIT : width_q;
		cfg.height  = (height_q > H_LIMIT) ? H_LIMIT : height_q;
	end

endmodule

`default_nettype wire

>>> hdl/mbpe_dist_stage.sv
`default_nettype none

module mbpe_dist_stage import mbpe_pkg::*; (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             en,
	input  wire logic                             in_valid,
	input  wire pix_t                             pix,
	input  wire logic [NUM_COLORS-1:0][RGB_W-1:0] palette,
	output logic                                  out_valid,
	output sqw_t                                  out_word
);

	logic                            valid_s2;
	logic [NUM_COLORS-1:0][SQ_W-1:0] sq;
	logic [NUM_COLORS-1:0][SQ_W-1:0] sq_s2;
	logic [POS_W-1:0]                x_s2;
	logic [POS_W-1:0]                y_s2;

	// Squared Euclidean distance to each palette entry, all lanes in parallel.
	always_comb begin
		logic [CH_W-1:0]   pr, pg, pb, dr, dg, db;
		logic [2*CH_W-1:0] qr, qg, qb;
		for (int l = 0; l < NUM_COLORS; l++) begin
			pr = palette[l][3*CH_W-1:2*CH_W];
			pg = palette[l][2*CH_W-1:CH_W];
			pb = palette[l][CH_W-1:0];
			dr = (pix.red > pr) ? pix.red - pr : pr - pix.red;
			dg = (pix.green > pg) ? pix.green - pg : pg - pix.green;
			db = (pix.blue > pb) ? pix.blue - pb : pb - pix.blue;
			qr = {{CH_W{1'b0}}, dr} * {{CH_W{1'b0}}, dr};
			qg = {{CH_W{1'b0}}, dg} * {{CH_W{1'b0}}, dg};
			qb = {{CH_W{1'b0}}, db} * {{CH_W{1'b0}}, db};
			sq[l] = SQ_W'(qr) + SQ_W'(qg) + SQ_W'(qb);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			sq_s2 <= sq;
			x_s2  <= pix.x;
			y_s2  <= pix.y;
		end
	end

	assign out_valid     = valid_s2;
	assign out_word.rad  = sq_s2;
	assign out_word.rem  = '0;
	assign out_word.root = '0;
	assign out_word.x    = x_s2;
	assign out_word.y    = y_s2;

endmodule

`default_nettype wire

>>> hdl/mbpe_sqrt_cell.sv
`default_nettype none

module mbpe_sqrt_cell import mbpe_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire sqw_t in_word,
	output logic      out_valid,
	output sqw_t      out_word
);

	logic valid_s1;
	sqw_t word_s1;
	sqw_t nxt;

	// One root bit per cell: bring down the next two radicand bits and try
	// to subtract 4*root+1 from the partial remainder.
	always_comb begin
		logic [REM_W+1:0] ext;
		logic [REM_W+1:0] trial;
		nxt = in_word;
		for (int l = 0; l < NUM_COLORS; l++) begin
			ext   = {in_word.rem[l], in_word.rad[l][SQ_W-1:SQ_W-2]};
			trial = {1'b0, in_word.root[l], 2'b01};
			nxt.rad[l] = {in_word.rad[l][SQ_W-3:0], 2'b00};
			if (ext >= trial) begin
				nxt.rem[l]  = REM_W'(ext - trial);
				nxt.root[l] = {in_word.root[l][ROOT_W-2:0], 1'b1};
			end else begin
				nxt.rem[l]  = ext[REM_W-1:0];
				nxt.root[l] = {in_word.root[l][ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			word_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_word  = word_s1;

endmodule

`default_nettype wire
